@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by slotted_leaf_page_engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a consequent holds whenever an antecedent holds.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/slpe_pkg.sv @@
// ----------------------------------------------------------------------------
// slpe_pkg
// Shared constants, codes and types of the slotted leaf page engine.
// ----------------------------------------------------------------------------
package slpe_pkg;

    localparam int PAGE_BYTES_DEF = 4096;
    localparam int FIRST_REC_DEF  = 32;
    localparam int MAX_KEY_DEF    = 256;
    localparam int SLOT_BYTES     = 2;
    localparam int HDR_BYTES      = 5;

    localparam int CMD_W  = 3;
    localparam int SLOT_W = 11;
    localparam int LEN_W  = 12;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;
    localparam int SIZE_W = 13;

    localparam logic [SLOT_W-1:0] MAX_SLOTS = 11'd2047;
    localparam logic [BYTE_W-1:0] DEL_MARK  = 8'h01;

    localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PAYLOAD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MARK    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_ROOM  = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_KEY_LONG = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_SEQ  = 3'd4;

    typedef enum logic [1:0] {
        P_IDLE   = 2'd0,
        P_INSERT = 2'd1,
        P_SEARCH = 2'd2
    } t_pend;

endpackage

@@ hw/rtl/slpe_if.sv @@
// ----------------------------------------------------------------------------
// slpe_in_if / slpe_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface slpe_in_if import slpe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot_sel;
    logic [LEN_W-1:0]  key_length;
    logic [LEN_W-1:0]  value_length;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, command, slot_sel, key_length, value_length,
                    data_byte, last_byte, input ready);
    modport sink (input valid, command, slot_sel, key_length, value_length,
                  data_byte, last_byte, output ready);
endinterface

interface slpe_out_if import slpe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] found_slot;
    logic              deleted_flag;
    logic [SLOT_W-1:0] record_count;
    logic [SIZE_W-1:0] free_bytes;
    logic [SIZE_W-1:0] dead_bytes;

    modport source (output valid, status, found_slot, deleted_flag, record_count,
                    free_bytes, dead_bytes, input ready);
    modport sink (input valid, status, found_slot, deleted_flag, record_count,
                  free_bytes, dead_bytes, output ready);
endinterface

@@ hw/rtl/slpe_ram.sv @@
// ----------------------------------------------------------------------------
// slpe_ram
// Generic one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
module slpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/slotted_leaf_page_engine.sv @@
// ----------------------------------------------------------------------------
// slotted_leaf_page_engine
// One slotted leaf page with ordered slot directory, init, insert, search,
// mark-deleted and query commands.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one command per transfer; o_result returns at most one
//   result per command. Insert and search are opened by a start command
//   and fed one payload byte per cycle; the result follows the last byte
//   once the commit or the search is done. Insert start writes the five
//   header bytes. Commit of an insert moves the directory below the new
//   slot down two bytes, each byte through a read and a write of the page
//   memory. Mark and query use two chained reads of the memory. A search
//   takes about log2(count) probes, each reading a directory entry and a key
//   length and then comparing key bytes one at a time; the single read port
//   of the page memory serialises these reads.
//   Reset empties the page and drops any pending operation; the page memory
//   holds no reset value and needs no clearing pass.
//   A held result blocks new transfers only until the receiver takes it;
//   an item is taken in the same cycle the result leaves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slotted_leaf_page_engine import slpe_pkg::*; #(
    parameter int PAGE_BYTES           = PAGE_BYTES_DEF,
    parameter int FIRST_RECORD_OFFSET  = FIRST_REC_DEF,
    parameter int MAX_SEARCH_KEY_BYTES = MAX_KEY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    slpe_in_if.sink        i_item,
    slpe_out_if.source     o_result
);

    localparam int AW = $clog2(PAGE_BYTES);
    localparam int OW = AW + 1;
    localparam int KW = $clog2(MAX_SEARCH_KEY_BYTES);
    localparam int JW = KW + 1;
    localparam int CW = (OW > 14) ? OW : 14;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_HDR    = 16'h0002,
        S_RD     = 16'h0004,
        S_MQ_REC = 16'h0008,
        S_MQ_FIN = 16'h0010,
        S_COMMIT = 16'h0020,
        S_SH_RD  = 16'h0040,
        S_SH_WR  = 16'h0080,
        S_SL_LO  = 16'h0100,
        S_SL_HI  = 16'h0200,
        S_PR_DIR = 16'h0400,
        S_PR_REC = 16'h0800,
        S_PR_KEY = 16'h1000,
        S_CMP_RD = 16'h2000,
        S_CMP_CK = 16'h4000,
        S_PR_DEC = 16'h8000
    } t_state;

    t_state            r_state;
    t_state            r_ret;
    t_pend             r_pend;
    logic [OW-1:0]     r_rae;
    logic [OW-1:0]     r_ds;
    logic [OW-1:0]     r_dead;
    logic [OW-1:0]     r_off;
    logic [SLOT_W-1:0] r_cnt;
    logic [12:0]       r_pcnt;
    logic [12:0]       r_ptot;
    logic [SLOT_W-1:0] r_pslot;
    logic [LEN_W-1:0]  r_pkey;
    logic [LEN_W-1:0]  r_pval;
    logic [2:0]        r_hdr;
    logic [11:0]       r_b;
    logic [AW-1:0]     r_raddr;
    logic [2:0]        r_rn;
    logic [2:0]        r_ri;
    logic              r_rv;
    logic [39:0]       r_acc;
    logic              r_mark;
    logic [AW-1:0]     r_rec;
    logic [SLOT_W-1:0] r_lo;
    logic [SLOT_W-1:0] r_hi;
    logic [SLOT_W-1:0] r_mid;
    logic [15:0]       r_rk;
    logic [JW-1:0]     r_n;
    logic [JW-1:0]     r_j;
    logic              r_below;
    logic              r_ovalid;
    logic [STAT_W-1:0] r_status;
    logic [SLOT_W-1:0] r_found;
    logic              r_flag;

    logic              accept;
    logic [12:0]       pay_cnt;
    logic [CW-1:0]     free_c;
    logic [CW-1:0]     need_c;
    logic [SLOT_W-1:0] pr_mid;
    logic [15:0]       acc_word;
    logic [15:0]       pr_rk;
    logic [SLOT_W-1:0] dec_lo;
    logic [SLOT_W-1:0] dec_hi;
    logic [31:0]       free_w;
    logic [31:0]       dead_w;
    logic [15:0]       off_w;

    logic              pg_we;
    logic [AW-1:0]     pg_waddr;
    logic [7:0]        pg_wdata;
    logic [AW-1:0]     pg_raddr;
    logic [7:0]        pg_q;
    logic              kb_we;
    logic [7:0]        kb_q;

    slpe_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_raddr (pg_raddr),
        .o_rdata (pg_q)
    );

    slpe_ram #(.WIDTH(8), .DEPTH(MAX_SEARCH_KEY_BYTES)) u_keybuf (
        .i_clk   (i_clk),
        .i_we    (kb_we),
        .i_waddr (r_pcnt[KW-1:0]),
        .i_wdata (i_item.data_byte),
        .i_raddr (r_j[KW-1:0]),
        .o_rdata (kb_q)
    );

    assign i_item.ready = (r_state == S_IDLE) && (!r_ovalid || o_result.ready);
    assign accept       = i_item.valid && i_item.ready;
    assign pay_cnt      = r_pcnt + 13'd1;
    assign free_c       = CW'(r_ds - r_rae);
    assign need_c       = CW'(HDR_BYTES) + CW'(i_item.key_length)
                        + CW'(i_item.value_length) + CW'(SLOT_BYTES);
    assign pr_mid       = SLOT_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign acc_word     = r_acc[39:24];
    assign pr_rk        = r_acc[39:24];
    assign dec_lo       = r_below ? (r_mid + 11'd1) : r_lo;
    assign dec_hi       = r_below ? r_hi : r_mid;
    assign free_w       = 32'(r_ds - r_rae);
    assign dead_w       = 32'(r_dead);
    assign off_w        = 16'(r_off);

    assign o_result.valid        = r_ovalid;
    assign o_result.status       = r_status;
    assign o_result.found_slot   = r_found;
    assign o_result.deleted_flag = r_flag;
    assign o_result.record_count = r_cnt;
    assign o_result.free_bytes   = free_w[SIZE_W-1:0];
    assign o_result.dead_bytes   = dead_w[SIZE_W-1:0];

    // page memory and key buffer ports
    always_comb begin
        pg_we    = 1'b0;
        pg_waddr = '0;
        pg_wdata = '0;
        pg_raddr = '0;
        kb_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_item.command == CMD_PAYLOAD) begin
                    pg_we    = (r_pend == P_INSERT);
                    kb_we    = (r_pend == P_SEARCH);
                    pg_waddr = r_rae[AW-1:0] + AW'(HDR_BYTES) + AW'(r_pcnt);
                    pg_wdata = i_item.data_byte;
                end
            end
            S_HDR: begin
                pg_we    = 1'b1;
                pg_waddr = r_rae[AW-1:0] + AW'(r_hdr);
                case (r_hdr)
                    3'd1:    pg_wdata = r_pkey[7:0];
                    3'd2:    pg_wdata = {4'd0, r_pkey[11:8]};
                    3'd3:    pg_wdata = r_pval[7:0];
                    3'd4:    pg_wdata = {4'd0, r_pval[11:8]};
                    default: pg_wdata = 8'h00;
                endcase
            end
            S_RD:     pg_raddr = r_raddr + AW'(r_ri);
            S_SH_RD:  pg_raddr = r_ds[AW-1:0] + AW'(r_b) + AW'(SLOT_BYTES);
            S_SH_WR: begin
                pg_we    = 1'b1;
                pg_waddr = r_ds[AW-1:0] + AW'(r_b);
                pg_wdata = pg_q;
            end
            S_SL_LO: begin
                pg_we    = 1'b1;
                pg_waddr = r_ds[AW-1:0] + AW'({r_pslot, 1'b0});
                pg_wdata = off_w[7:0];
            end
            S_SL_HI: begin
                pg_we    = 1'b1;
                pg_waddr = r_ds[AW-1:0] + AW'({r_pslot, 1'b0}) + AW'(1);
                pg_wdata = off_w[15:8];
            end
            S_MQ_FIN: begin
                pg_we    = r_mark && !r_acc[0];
                pg_waddr = r_rec;
                pg_wdata = r_acc[7:0] | DEL_MARK;
            end
            S_CMP_RD: pg_raddr = r_rec + AW'(HDR_BYTES) + AW'(r_j);
            default: begin
                pg_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= P_IDLE;
            r_pcnt   <= '0;
            r_rae    <= OW'(FIRST_RECORD_OFFSET);
            r_ds     <= OW'(PAGE_BYTES);
            r_cnt    <= '0;
            r_dead   <= '0;
            r_ovalid <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            if (o_result.valid && o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status <= ST_BAD_SEQ;
                        r_found  <= '0;
                        r_flag   <= 1'b0;
                        case (i_item.command)
                            CMD_INIT: begin
                                r_rae    <= OW'(FIRST_RECORD_OFFSET);
                                r_ds     <= OW'(PAGE_BYTES);
                                r_cnt    <= '0;
                                r_dead   <= '0;
                                r_pend   <= P_IDLE;
                                r_pcnt   <= '0;
                                r_status <= ST_OK;
                                r_ovalid <= 1'b1;
                            end
                            CMD_PAYLOAD: begin
                                if (r_pend == P_IDLE) begin
                                    r_ovalid <= 1'b1;
                                end else if (i_item.last_byte && pay_cnt == r_ptot) begin
                                    r_pend <= P_IDLE;
                                    r_pcnt <= '0;
                                    if (r_pend == P_INSERT) begin
                                        r_state <= S_COMMIT;
                                    end else begin
                                        r_lo <= '0;
                                        r_hi <= r_cnt;
                                        if (r_cnt == '0) begin
                                            r_status <= ST_OK;
                                            r_ovalid <= 1'b1;
                                        end else begin
                                            r_state <= S_PR_DIR;
                                        end
                                    end
                                end else if (i_item.last_byte || pay_cnt >= r_ptot) begin
                                    r_pend   <= P_IDLE;
                                    r_pcnt   <= '0;
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_pcnt <= pay_cnt;
                                end
                            end
                            CMD_INSERT, CMD_SEARCH, CMD_MARK, CMD_QUERY: begin
                                if (r_pend != P_IDLE) begin
                                    r_pend   <= P_IDLE;
                                    r_pcnt   <= '0;
                                    r_ovalid <= 1'b1;
                                end else if (i_item.command == CMD_INSERT) begin
                                    if (i_item.slot_sel > r_cnt) begin
                                        r_status <= ST_RANGE;
                                        r_ovalid <= 1'b1;
                                    end else if (r_cnt == MAX_SLOTS || free_c < need_c) begin
                                        r_status <= ST_NO_ROOM;
                                        r_ovalid <= 1'b1;
                                    end else begin
                                        r_pslot <= i_item.slot_sel;
                                        r_pkey  <= i_item.key_length;
                                        r_pval  <= i_item.value_length;
                                        r_ptot  <= 13'(i_item.key_length)
                                                 + 13'(i_item.value_length);
                                        r_pcnt  <= '0;
                                        r_hdr   <= '0;
                                        r_state <= S_HDR;
                                    end
                                end else if (i_item.command == CMD_SEARCH) begin
                                    if (32'(i_item.key_length) > 32'(MAX_SEARCH_KEY_BYTES)) begin
                                        r_status <= ST_KEY_LONG;
                                        r_ovalid <= 1'b1;
                                    end else if (i_item.key_length == '0) begin
                                        r_status <= ST_OK;
                                        r_ovalid <= 1'b1;
                                    end else begin
                                        r_pkey <= i_item.key_length;
                                        r_ptot <= 13'(i_item.key_length);
                                        r_pcnt <= '0;
                                        r_pend <= P_SEARCH;
                                    end
                                end else if (i_item.slot_sel >= r_cnt) begin
                                    r_status <= ST_RANGE;
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_mark  <= (i_item.command == CMD_MARK);
                                    r_raddr <= r_ds[AW-1:0] + AW'({i_item.slot_sel, 1'b0});
                                    r_rn    <= 3'd2;
                                    r_ri    <= '0;
                                    r_rv    <= 1'b0;
                                    r_ret   <= S_MQ_REC;
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_ovalid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_HDR: begin
                    r_hdr <= r_hdr + 3'd1;
                    if (r_hdr == 3'(HDR_BYTES - 1)) begin
                        if (r_ptot == '0) begin
                            r_state <= S_COMMIT;
                        end else begin
                            r_pend  <= P_INSERT;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RD: begin
                    if (r_rv) begin
                        r_acc <= {pg_q, r_acc[39:8]};
                    end
                    if (r_ri < r_rn) begin
                        r_ri <= r_ri + 3'd1;
                        r_rv <= 1'b1;
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_ri == r_rn && r_rv) begin
                        r_state <= r_ret;
                    end
                end
                S_MQ_REC: begin
                    r_rec   <= AW'(acc_word);
                    r_raddr <= AW'(acc_word);
                    r_rn    <= 3'(HDR_BYTES);
                    r_ri    <= '0;
                    r_ret   <= S_MQ_FIN;
                    r_state <= S_RD;
                end
                S_MQ_FIN: begin
                    if (r_mark && !r_acc[0]) begin
                        r_dead <= r_dead + OW'(18'(HDR_BYTES) + 18'(r_acc[23:8])
                                               + 18'(r_acc[39:24]));
                    end
                    r_status <= ST_OK;
                    r_flag   <= r_mark ? 1'b0 : r_acc[0];
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_COMMIT: begin
                    r_off   <= r_rae;
                    r_rae   <= r_rae + OW'(HDR_BYTES) + OW'(r_ptot);
                    r_ds    <= r_ds - OW'(SLOT_BYTES);
                    r_b     <= '0;
                    r_state <= (r_pslot == '0) ? S_SL_LO : S_SH_RD;
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    r_b     <= r_b + 12'd1;
                    r_state <= (r_b + 12'd1 == {r_pslot, 1'b0}) ? S_SL_LO : S_SH_RD;
                end
                S_SL_LO: begin
                    r_state <= S_SL_HI;
                end
                S_SL_HI: begin
                    r_cnt    <= r_cnt + 11'd1;
                    r_status <= ST_OK;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_PR_DIR: begin
                    r_mid   <= pr_mid;
                    r_raddr <= r_ds[AW-1:0] + AW'({pr_mid, 1'b0});
                    r_rn    <= 3'd2;
                    r_ri    <= '0;
                    r_ret   <= S_PR_REC;
                    r_state <= S_RD;
                end
                S_PR_REC: begin
                    r_rec   <= AW'(acc_word);
                    r_raddr <= AW'(acc_word) + AW'(1);
                    r_rn    <= 3'd2;
                    r_ri    <= '0;
                    r_ret   <= S_PR_KEY;
                    r_state <= S_RD;
                end
                S_PR_KEY: begin
                    r_rk <= pr_rk;
                    r_j  <= '0;
                    r_n  <= (pr_rk < 16'(r_pkey)) ? JW'(pr_rk) : JW'(r_pkey);
                    if (pr_rk == '0) begin
                        r_below <= (pr_rk < 16'(r_pkey));
                        r_state <= S_PR_DEC;
                    end else begin
                        r_state <= S_CMP_RD;
                    end
                end
                S_CMP_RD: begin
                    r_state <= S_CMP_CK;
                end
                S_CMP_CK: begin
                    if (pg_q != kb_q) begin
                        r_below <= (pg_q < kb_q);
                        r_state <= S_PR_DEC;
                    end else begin
                        r_j <= r_j + JW'(1);
                        if (r_j + JW'(1) == r_n) begin
                            r_below <= (r_rk < 16'(r_pkey));
                            r_state <= S_PR_DEC;
                        end else begin
                            r_state <= S_CMP_RD;
                        end
                    end
                end
                S_PR_DEC: begin
                    r_lo <= dec_lo;
                    r_hi <= dec_hi;
                    if (dec_lo < dec_hi) begin
                        r_state <= S_PR_DIR;
                    end else begin
                        r_status <= ST_OK;
                        r_found  <= dec_lo;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_state_onehot, $onehot(r_state), "state register not one-hot")
    `ASSERT_ALWAYS(a_gap_order, r_ds >= r_rae, "record area overlaps directory")
    `ASSERT_IMPLY(a_result_idle, r_ovalid, r_state == S_IDLE, "result held while busy")
    `ASSERT_IMPLY(a_pend_idle, r_pend != P_IDLE, r_state == S_IDLE, "pending op while busy")

endmodule
